// ----- sv/maf_pkg.sv -----
// shared constants for the 802.15.4 mac frame address filter
// no dependencies

package maf_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned FlagsWidth  = 5;
   localparam int unsigned ReasonWidth = 3;
   localparam int unsigned PosWidth    = 4;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDataWidth = 64;

   // filter flag bits
   localparam int unsigned FlagPassAll   = 0;
   localparam int unsigned FlagBeacon    = 1;
   localparam int unsigned FlagShort     = 2;
   localparam int unsigned FlagDataShort = 3;
   localparam int unsigned FlagLong      = 4;

   // frame control bits
   localparam int unsigned FcSeqSuppress = 8;
   localparam int unsigned FcDestLong    = 10;
   localparam int unsigned FcDestPresent = 11;
   localparam logic [2:0] FrameTypeBeacon = 3'd0;
   localparam logic [2:0] FrameTypeData   = 3'd1;

   localparam logic [15:0] AnyPan         = 16'hffff;
   localparam logic [15:0] BroadcastShort = 16'hffff;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] RegFlags = 2'd0;
   localparam logic [CsrIdxWidth-1:0] RegPanId = 2'd1;
   localparam logic [CsrIdxWidth-1:0] RegShort = 2'd2;
   localparam logic [CsrIdxWidth-1:0] RegLong  = 2'd3;

   typedef enum logic [ReasonWidth-1:0] {
      REASON_OK    = 3'd0,
      REASON_SEQ   = 3'd1,
      REASON_PAN   = 3'd2,
      REASON_ADDR  = 3'd3,
      REASON_SHORT = 3'd4
   } reason_type;

endpackage

// ----- sv/mac_frame_address_filter_core.sv -----
// top level of the 802.15.4 mac frame address filter
// depends on maf_pkg for widths, flag positions and reason codes

// Takes the MAC bytes of a received 802.15.4 frame, one word per cycle, and
// gives one accept/reject verdict per frame on the byte that settles it, or
// at frame end with reason "too short". A word is accepted into an input
// register and judged on its way into the result register, so one word can
// be taken every cycle; the input stalls only when a word that yields a
// verdict finds the result register still held by a stalled verdict.
// The verdict enters the result register as the word settling it leaves the
// input register. Configuration is written through the csr port, which is
// always ready; write it only when the block is idle.

module mac_frame_address_filter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [maf_pkg::ByteWidth-1:0]        req_frame_byte,
   input  logic                                 req_frame_start,
   input  logic                                 req_frame_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_accept,
   output logic [maf_pkg::ReasonWidth-1:0]      rsp_reject_reason,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [maf_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [maf_pkg::CsrDataWidth-1:0]     csr_data
);

   // configuration registers
   logic [maf_pkg::FlagsWidth-1:0] flags_ff;
   logic [15:0]                    pan_id_ff;
   logic [15:0]                    short_addr_ff;
   logic [63:0]                    long_addr_ff;

   // input register
   logic                           s1_valid_ff;
   logic [maf_pkg::ByteWidth-1:0]  s1_byte_ff;
   logic                           s1_start_ff;
   logic                           s1_end_ff;

   // frame state
   logic [maf_pkg::PosWidth-1:0]   pos_ff, pos_in;
   logic                           verdict_ff, verdict_in;
   logic [15:0]                    fc_ff;
   logic [7:0]                     pan_lo_ff;
   logic [55:0]                    addr_ff;

   // result register
   logic                           rsp_valid_ff;
   logic                           rsp_accept_ff;
   maf_pkg::reason_type            reason_ff;

   logic [maf_pkg::PosWidth-1:0]   pos_eff;
   logic                           verdict_eff;
   logic                           judged;
   maf_pkg::reason_type            judge_reason;
   maf_pkg::reason_type            reason_in;
   logic                           have_result;
   logic                           out_free;
   logic                           s1_go;
   logic [15:0]                    fc_new;
   logic [15:0]                    pan_new;
   logic [15:0]                    short_seen;
   logic [63:0]                    long_seen;
   logic [2:0]                     fc_type;
   logic                           short_en;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff      <= '0;
         pan_id_ff     <= '0;
         short_addr_ff <= '0;
         long_addr_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            maf_pkg::RegFlags: flags_ff      <= csr_data[maf_pkg::FlagsWidth-1:0];
            maf_pkg::RegPanId: pan_id_ff     <= csr_data[15:0];
            maf_pkg::RegShort: short_addr_ff <= csr_data[15:0];
            maf_pkg::RegLong:  long_addr_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // a start word restarts the frame, wherever the old one stood
   assign pos_eff     = s1_start_ff ? '0 : pos_ff;
   assign verdict_eff = s1_start_ff ? 1'b0 : verdict_ff;

   assign fc_new     = {s1_byte_ff, fc_ff[7:0]};
   assign pan_new    = {s1_byte_ff, pan_lo_ff};
   assign short_seen = {s1_byte_ff, addr_ff[7:0]};
   assign long_seen  = {s1_byte_ff, addr_ff};
   assign fc_type    = fc_ff[2:0];
   assign short_en   = flags_ff[maf_pkg::FlagShort] ||
                       (flags_ff[maf_pkg::FlagDataShort] && fc_type == maf_pkg::FrameTypeData);

   always_comb begin
      judged       = 1'b0;
      judge_reason = maf_pkg::REASON_OK;
      case (pos_eff)
         4'd0: begin
            judged = flags_ff[maf_pkg::FlagPassAll];
         end
         4'd1: begin
            if (fc_new[maf_pkg::FcSeqSuppress]) begin
               judged       = 1'b1;
               judge_reason = maf_pkg::REASON_SEQ;
            end else if (flags_ff[maf_pkg::FlagBeacon] &&
                         fc_new[2:0] == maf_pkg::FrameTypeBeacon) begin
               judged = 1'b1;
            end else if (!fc_new[maf_pkg::FcDestPresent]) begin
               judged       = 1'b1;
               judge_reason = maf_pkg::REASON_ADDR;
            end
         end
         4'd4: begin
            if (pan_new != maf_pkg::AnyPan && pan_new != pan_id_ff) begin
               judged       = 1'b1;
               judge_reason = maf_pkg::REASON_PAN;
            end else if (!fc_ff[maf_pkg::FcDestLong] && !short_en) begin
               judged       = 1'b1;
               judge_reason = maf_pkg::REASON_ADDR;
            end else if (fc_ff[maf_pkg::FcDestLong] && !flags_ff[maf_pkg::FlagLong]) begin
               judged       = 1'b1;
               judge_reason = maf_pkg::REASON_ADDR;
            end
         end
         4'd6: begin
            // second address byte settles a short destination
            if (!fc_ff[maf_pkg::FcDestLong]) begin
               judged = 1'b1;
               if (short_seen != maf_pkg::BroadcastShort && short_seen != short_addr_ff)
                  judge_reason = maf_pkg::REASON_ADDR;
            end
         end
         4'd12: begin
            if (fc_ff[maf_pkg::FcDestLong]) begin
               judged = 1'b1;
               if (long_seen != long_addr_ff)
                  judge_reason = maf_pkg::REASON_ADDR;
            end
         end
         default: ;
      endcase
   end

   assign have_result = !verdict_eff && (judged || s1_end_ff);
   assign reason_in   = judged ? judge_reason : maf_pkg::REASON_SHORT;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_go       = !have_result || out_free;
   assign req_stall   = s1_valid_ff && !s1_go;

   always_comb begin
      if (s1_end_ff)
         pos_in = '0;
      else if (pos_eff != '1)
         pos_in = pos_eff + 1'b1;
      else
         pos_in = pos_eff;
      verdict_in = s1_end_ff ? 1'b0 : (verdict_eff || have_result);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         verdict_ff   <= 1'b0;
         fc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall)
            s1_valid_ff <= req_valid;
         if (s1_valid_ff && s1_go) begin
            pos_ff     <= pos_in;
            verdict_ff <= verdict_in;
            if (!verdict_eff) begin
               if (pos_eff == 4'd0)
                  fc_ff <= {8'h00, s1_byte_ff};
               else if (pos_eff == 4'd1)
                  fc_ff <= fc_new;
            end
         end
         if (out_free)
            rsp_valid_ff <= s1_valid_ff && have_result;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_byte_ff  <= req_frame_byte;
         s1_start_ff <= req_frame_start;
         s1_end_ff   <= req_frame_end;
      end
      if (s1_valid_ff && s1_go && !verdict_eff) begin
         if (pos_eff == 4'd3)
            pan_lo_ff <= s1_byte_ff;
         case (pos_eff)
            4'd5:  addr_ff[7:0]   <= s1_byte_ff;
            4'd6:  addr_ff[15:8]  <= s1_byte_ff;
            4'd7:  addr_ff[23:16] <= s1_byte_ff;
            4'd8:  addr_ff[31:24] <= s1_byte_ff;
            4'd9:  addr_ff[39:32] <= s1_byte_ff;
            4'd10: addr_ff[47:40] <= s1_byte_ff;
            4'd11: addr_ff[55:48] <= s1_byte_ff;
            default: ;
         endcase
      end
      if (out_free && s1_valid_ff && have_result) begin
         rsp_accept_ff <= (reason_in == maf_pkg::REASON_OK);
         reason_ff     <= reason_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accept        = rsp_accept_ff;
   assign rsp_reject_reason = reason_ff;

   // accept flag and reason code agree
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_accept_ff == (reason_ff == maf_pkg::REASON_OK)))
      else $error("accept flag disagrees with reason");

   // a verdict inside a frame blocks further verdicts until the frame ends
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_go && have_result && !s1_end_ff) |=> verdict_ff)
      else $error("verdict not recorded");

   // a frame end always clears the frame state
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_go && s1_end_ff) |=> (pos_ff == '0 && !verdict_ff))
      else $error("frame state not cleared at frame end");

   // input stalls only behind a verdict that cannot move on
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && have_result && rsp_valid_ff && rsp_stall))
      else $error("spurious input stall");

endmodule

// ----- tb/mac_frame_address_filter_core_tb.sv -----
// self-checking testbench for the 802.15.4 mac frame address filter
// predicts each verdict from the bytes taken and the register values written
// depends on maf_pkg and mac_frame_address_filter_core

`timescale 1ns / 1ps

module mac_frame_address_filter_core_tb;

   localparam int ClockPeriod  = 12;
   localparam int ResetCycles  = 7;
   localparam int DrainCycles  = 8;
   localparam int CycleLimit   = 400000;
   localparam int PhaseBytes   = 175;
   localparam int RandomPhases = 8;

   typedef struct packed {
      logic [maf_pkg::ByteWidth-1:0] data;
      logic                          first;
      logic                          last;
   } rx_byte_type;

   typedef struct packed {
      logic                accept;
      maf_pkg::reason_type why;
   } verdict_type;

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [maf_pkg::ByteWidth-1:0]    req_frame_byte = '0;
   logic                             req_frame_start = 1'b0;
   logic                             req_frame_end = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_accept;
   logic [maf_pkg::ReasonWidth-1:0]  rsp_reject_reason;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [maf_pkg::CsrIdxWidth-1:0]  csr_index = '0;
   logic [maf_pkg::CsrDataWidth-1:0] csr_data = '0;

   // filter settings as last written
   logic [maf_pkg::FlagsWidth-1:0] own_flags = '0;
   logic [15:0]                    own_pan = '0;
   logic [15:0]                    own_short = '0;
   logic [63:0]                    own_long = '0;

   // frame tracking of the predictor
   logic [maf_pkg::PosWidth-1:0]   fr_pos = '0;
   logic [15:0]                    fr_control = '0;
   logic [15:0]                    fr_pan = '0;
   logic [63:0]                    fr_dest = '0;
   logic                           fr_settled = 1'b0;

   rx_byte_type bytes_to_send[$];
   verdict_type verdicts_due[$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int bytes_taken = 0;
   int verdicts_checked = 0;
   int settings_used = 0;
   int cycles = 0;
   int reason_hits [5] = '{default: 0};

   mac_frame_address_filter_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_frame_byte    (req_frame_byte),
      .req_frame_start   (req_frame_start),
      .req_frame_end     (req_frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accept        (rsp_accept),
      .rsp_reject_reason (rsp_reject_reason),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // works out the verdict, if any, that one received byte settles
   task automatic judge_rx_byte(input rx_byte_type w, output logic got, output verdict_type v);
      logic [15:0]         fcw;
      logic [15:0]         pan;
      logic                short_en;
      logic                decided;
      maf_pkg::reason_type why;
      int                  k;
      got = 1'b0;
      v = '{accept: 1'b0, why: maf_pkg::REASON_OK};
      decided = 1'b0;
      why = maf_pkg::REASON_OK;
      if (w.first) begin
         fr_pos = '0;
         fr_settled = 1'b0;
      end
      if (!fr_settled) begin
         fcw = fr_control;
         case (fr_pos)
            4'd0: begin
               fr_control = {8'h00, w.data};
               if (own_flags[maf_pkg::FlagPassAll]) begin
                  decided = 1'b1;
                  why = maf_pkg::REASON_OK;
               end
            end
            4'd1: begin
               fcw = {w.data, fr_control[7:0]};
               fr_control = fcw;
               if (fcw[maf_pkg::FcSeqSuppress]) begin
                  decided = 1'b1;
                  why = maf_pkg::REASON_SEQ;
               end else if (own_flags[maf_pkg::FlagBeacon] &&
                            fcw[2:0] == maf_pkg::FrameTypeBeacon) begin
                  decided = 1'b1;
                  why = maf_pkg::REASON_OK;
               end else if (!fcw[maf_pkg::FcDestPresent]) begin
                  decided = 1'b1;
                  why = maf_pkg::REASON_ADDR;
               end
            end
            4'd2: ;
            4'd3: fr_pan = {8'h00, w.data};
            4'd4: begin
               pan = {w.data, fr_pan[7:0]};
               fr_pan = pan;
               short_en = own_flags[maf_pkg::FlagShort] ||
                          (own_flags[maf_pkg::FlagDataShort] &&
                           fcw[2:0] == maf_pkg::FrameTypeData);
               if (pan != maf_pkg::AnyPan && pan != own_pan) begin
                  decided = 1'b1;
                  why = maf_pkg::REASON_PAN;
               end else if (!fcw[maf_pkg::FcDestLong] && !short_en) begin
                  decided = 1'b1;
                  why = maf_pkg::REASON_ADDR;
               end else if (fcw[maf_pkg::FcDestLong] && !own_flags[maf_pkg::FlagLong]) begin
                  decided = 1'b1;
                  why = maf_pkg::REASON_ADDR;
               end
            end
            default: begin
               if (fr_pos <= 4'd12) begin
                  k = int'(fr_pos) - 5;
                  if (k == 0) fr_dest = '0;
                  fr_dest = fr_dest | ({56'd0, w.data} << (8 * k));
                  if (!fcw[maf_pkg::FcDestLong]) begin
                     if (k == 1) begin
                        decided = 1'b1;
                        why = (fr_dest[15:0] == maf_pkg::BroadcastShort ||
                               fr_dest[15:0] == own_short) ?
                              maf_pkg::REASON_OK : maf_pkg::REASON_ADDR;
                     end
                  end else if (k == 7) begin
                     decided = 1'b1;
                     why = (fr_dest == own_long) ? maf_pkg::REASON_OK : maf_pkg::REASON_ADDR;
                  end
               end
            end
         endcase
         if (!decided && w.last) begin
            decided = 1'b1;
            why = maf_pkg::REASON_SHORT;
         end
      end
      if (fr_pos != 4'hf) fr_pos = fr_pos + 1'b1;
      if (decided) begin
         fr_settled = 1'b1;
         got = 1'b1;
         v.accept = (why == maf_pkg::REASON_OK);
         v.why = why;
      end
      if (w.last) begin
         fr_pos = '0;
         fr_settled = 1'b0;
      end
   endtask

   // byte sender, predicts on every word taken
   always @(posedge clock) begin : drive_bytes
      logic        got;
      verdict_type v;
      rx_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            judge_rx_byte({req_frame_byte, req_frame_start, req_frame_end}, got, v);
            bytes_taken++;
            if (got) verdicts_due.push_back(v);
         end
         if (!req_valid || !req_stall) begin
            if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = bytes_to_send.pop_front();
               req_valid <= 1'b1;
               req_frame_byte <= nxt.data;
               req_frame_start <= nxt.first;
               req_frame_end <= nxt.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_verdicts
      verdict_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdicts_due.size() == 0) begin
               $display("%0t: unexpected verdict, expected none, got accept %0b reason %0d",
                        $time, rsp_accept, rsp_reject_reason);
               mismatches++;
            end else begin
               want = verdicts_due.pop_front();
               verdicts_checked++;
               reason_hits[int'(want.why)]++;
               if (rsp_accept !== want.accept) begin
                  $display("%0t: accept mismatch, expected %0b, got %0b",
                           $time, want.accept, rsp_accept);
                  mismatches++;
               end
               if (rsp_reject_reason !== want.why) begin
                  $display("%0t: reject reason mismatch, expected %0d, got %0d",
                           $time, want.why, rsp_reject_reason);
                  mismatches++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("%0t: run timed out with %0d verdicts outstanding", $time, verdicts_due.size());
         $display("[mac_frame_address_filter_core] ERROR");
         $finish;
      end
   end

   // called at a rising edge, returns at the edge of the write
   task automatic write_reg(input logic [maf_pkg::CsrIdxWidth-1:0] idx,
                            input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         maf_pkg::RegFlags: own_flags = val[maf_pkg::FlagsWidth-1:0];
         maf_pkg::RegPanId: own_pan = val[15:0];
         maf_pkg::RegShort: own_short = val[15:0];
         maf_pkg::RegLong:  own_long = val;
      endcase
   endtask

   task automatic set_filter(input logic [63:0] fl, input logic [63:0] pan,
                             input logic [63:0] sa, input logic [63:0] la);
      write_reg(maf_pkg::RegFlags, fl);
      write_reg(maf_pkg::RegPanId, pan);
      write_reg(maf_pkg::RegShort, sa);
      write_reg(maf_pkg::RegLong, la);
      csr_valid <= 1'b0;
      settings_used++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (bytes_to_send.size() != 0 || req_valid || verdicts_due.size() != 0);
      // words that settle nothing may still be in the pipeline
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic queue_byte(input logic [7:0] data, input logic first, input logic last);
      bytes_to_send.push_back('{data: data, first: first, last: last});
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // mostly well-formed headers aimed at own pan and addresses, some cut short or noise
   task automatic queue_random_frame();
      logic [7:0]  fb[$];
      logic [7:0]  hi;
      logic [2:0]  ftype;
      logic [15:0] pan;
      logic [15:0] sa;
      logic [63:0] la;
      logic        has_start;
      logic        has_end;
      int          r;
      int          cut;
      r = $urandom_range(99);
      if (r < 8) begin
         repeat ($urandom_range(1, 4))
            queue_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
         return;
      end
      r = $urandom_range(99);
      ftype = (r < 40) ? maf_pkg::FrameTypeData : (r < 65) ? maf_pkg::FrameTypeBeacon :
              3'($urandom_range(7));
      fb.push_back({5'($urandom_range(31)), ftype});
      hi = 8'($urandom_range(255));
      hi[maf_pkg::FcSeqSuppress-8] = ($urandom_range(99) < 10);
      if ($urandom_range(99) < 75) begin
         hi[maf_pkg::FcDestPresent-8] = 1'b1;
         hi[maf_pkg::FcDestLong-8] = 1'($urandom_range(1));
      end
      fb.push_back(hi);
      fb.push_back(8'($urandom_range(255)));
      r = $urandom_range(99);
      pan = (r < 45) ? own_pan : (r < 65) ? maf_pkg::AnyPan : 16'($urandom_range(65535));
      fb.push_back(pan[7:0]);
      fb.push_back(pan[15:8]);
      r = $urandom_range(99);
      if (hi[maf_pkg::FcDestLong-8]) begin
         la = (r < 50) ? own_long : (r < 75) ? own_long ^ (64'd1 << $urandom_range(63)) :
              rand64();
         for (int i = 0; i < 8; i++) fb.push_back(la[8*i +: 8]);
      end else begin
         sa = (r < 40) ? own_short : (r < 60) ? maf_pkg::BroadcastShort :
              (r < 80) ? own_short ^ (16'd1 << $urandom_range(15)) :
              16'($urandom_range(65535));
         fb.push_back(sa[7:0]);
         fb.push_back(sa[15:8]);
      end
      repeat ($urandom_range(0, 4)) fb.push_back(8'($urandom_range(255)));
      cut = fb.size();
      if ($urandom_range(99) < 12) cut = $urandom_range(1, fb.size());
      has_start = ($urandom_range(99) < 88);
      has_end = ($urandom_range(99) < 92);
      for (int i = 0; i < cut; i++)
         queue_byte(fb[i], i == 0 && has_start, i == cut - 1 && has_end);
   endtask

   initial begin : run_phases
      logic [maf_pkg::FlagsWidth-1:0] fl;
      logic [63:0]                    fl_word;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // seq suppression, no destination, short and long matching, broadcast pan, truncation and restarts
      fl = '0;
      fl[maf_pkg::FlagShort] = 1'b1;
      fl[maf_pkg::FlagLong] = 1'b1;
      set_filter({59'd0, fl}, 64'h1234, 64'habcd, 64'h0123_4567_89ab_cdef);
      queue_byte(8'h01, 1'b1, 1'b0); queue_byte(8'h09, 1'b0, 1'b1);
      queue_byte(8'h01, 1'b0, 1'b0); queue_byte(8'h04, 1'b0, 1'b1);
      queue_byte(8'h01, 1'b1, 1'b0); queue_byte(8'h08, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'hff, 1'b0, 1'b0); queue_byte(8'hff, 1'b0, 1'b0);
      queue_byte(8'hcd, 1'b0, 1'b0);
      queue_byte(8'hab, 1'b0, 1'b1);
      queue_byte(8'h01, 1'b1, 1'b0); queue_byte(8'h08, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b1);
      queue_byte(8'h41, 1'b1, 1'b0);
      queue_byte(8'h41, 1'b1, 1'b0); queue_byte(8'h0c, 1'b0, 1'b0);
      queue_byte(8'h07, 1'b0, 1'b0);
      queue_byte(8'h34, 1'b0, 1'b0); queue_byte(8'h12, 1'b0, 1'b0);
      queue_byte(8'hef, 1'b0, 1'b0); queue_byte(8'hcd, 1'b0, 1'b0);
      queue_byte(8'hab, 1'b0, 1'b0);
      queue_byte(8'h89, 1'b0, 1'b0); queue_byte(8'h67, 1'b0, 1'b0);
      queue_byte(8'h45, 1'b0, 1'b0);
      queue_byte(8'h23, 1'b0, 1'b0); queue_byte(8'h01, 1'b0, 1'b0);
      queue_byte(8'h55, 1'b0, 1'b1);
      wait_drained();

      // beacon pass, data-only short matching, pan mismatch
      fl = '0;
      fl[maf_pkg::FlagBeacon] = 1'b1;
      fl[maf_pkg::FlagDataShort] = 1'b1;
      set_filter({59'd0, fl}, 64'h1234, 64'habcd, 64'h0123_4567_89ab_cdef);
      queue_byte(8'h00, 1'b1, 1'b0); queue_byte(8'h00, 1'b0, 1'b1);
      queue_byte(8'h03, 1'b1, 1'b0); queue_byte(8'h08, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'h34, 1'b0, 1'b0); queue_byte(8'h12, 1'b0, 1'b1);
      queue_byte(8'h01, 1'b1, 1'b0); queue_byte(8'h08, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'h34, 1'b0, 1'b0); queue_byte(8'h13, 1'b0, 1'b1);
      wait_drained();

      fl = '0;
      fl[maf_pkg::FlagPassAll] = 1'b1;
      set_filter({59'd0, fl}, 64'h1234, 64'habcd, 64'h0123_4567_89ab_cdef);
      queue_byte(8'ha7, 1'b1, 1'b1);

      for (int ph = 0; ph < RandomPhases; ph++) begin
         wait_drained();
         // upper bits of the narrow registers carry noise that must be ignored
         fl_word = rand64();
         case (ph)
            0: set_filter(64'd0, 64'd0, 64'd0, 64'd0);
            1: set_filter({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
            2: set_filter({fl_word[63:5], 5'h1e}, {48'd0, maf_pkg::AnyPan},
                          {48'd0, maf_pkg::BroadcastShort}, {64{1'b1}});
            3: set_filter({fl_word[63:5], 5'h01}, rand64(), rand64(), rand64());
            default: begin
               fl_word[maf_pkg::FlagPassAll] = 1'b0;
               set_filter(fl_word, rand64(), rand64(), rand64());
            end
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 64; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 64; end
            default: begin send_idle_pct = 35; stall_pct = 35; end
         endcase
         while (bytes_to_send.size() < PhaseBytes) queue_random_frame();
         // close any open frame before the next register writes
         queue_byte(8'($urandom_range(255)), 1'b1, 1'b1);
      end
      wait_drained();

      $display("%0d bytes under %0d filter settings, %0d verdicts checked",
               bytes_taken, settings_used, verdicts_checked);
      $display("verdicts: %0d accept, %0d seq suppressed, %0d pan, %0d address, %0d too short",
               reason_hits[0], reason_hits[1], reason_hits[2], reason_hits[3], reason_hits[4]);
      if (mismatches == 0) begin
         $display("[mac_frame_address_filter_core] OK");
      end else begin
         $display("[mac_frame_address_filter_core] ERROR");
      end
      $finish;
   end

endmodule
